>>> src/skvt_pkg.sv
// Shared types and codes for the sorted key/value table.
// Used by the channel interfaces, the table cell and the top level.
package skvt_pkg;

  // Fixed field widths of the transaction payloads.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VAL_IN_W = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 7;

  typedef logic [OP_W-1:0]     op_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [VAL_IN_W-1:0] val_in_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [COUNT_W-1:0]  count_out_t;

  // Operation codes.
  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_LOOKUP = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  // Result status codes.
  localparam status_t STAT_INSERTED  = 3'd0;
  localparam status_t STAT_OVERWROTE = 3'd1;
  localparam status_t STAT_FOUND     = 3'd2;
  localparam status_t STAT_NOT_FOUND = 3'd3;
  localparam status_t STAT_FULL      = 3'd4;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic compare;    // compare the stored key with the broadcast key
    logic insert;     // open a slot at the sorted position and fill it
    logic remove;     // close the slot at the sorted position
    logic overwrite;  // replace the value of the matching entry
  } cell_cmd_t;

endpackage

>>> src/skvt_in_if.sv
// Request channel of the sorted key/value table.
// Depends on skvt_pkg for the payload types.
interface skvt_in_if;
  import skvt_pkg::*;

  logic    valid;
  logic    ready;
  op_t     operation;
  key_t    key;
  val_in_t value;

  modport source (output valid, output operation, output key, output value, input ready);
  modport sink   (input valid, input operation, input key, input value, output ready);
endinterface

>>> src/skvt_out_if.sv
// Result channel of the sorted key/value table.
// Depends on skvt_pkg for the payload types.
interface skvt_out_if;
  import skvt_pkg::*;

  logic       valid;
  logic       ready;
  status_t    status;
  val_in_t    value_out;
  count_out_t entry_count;

  modport source (output valid, output status, output value_out, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input value_out, input entry_count,
                  output ready);
endinterface

>>> src/sorted_key_value_table_core.sv
// Top level of the sorted key/value table: a chain of skvt_cell slots and
// the controller that sequences each transaction. Depends on skvt_pkg,
// skvt_in_if, skvt_out_if and skvt_cell.
//
// Usage:
//   in_chan carries one request per transaction: operation (insert, lookup,
//   remove), a 64-bit key and a value. out_chan returns one result per
//   request, in order: status, the value found (zero otherwise) and the
//   number of entries held after the operation.
// Sequencing:
//   A request is captured into the request registers; then all cells compare
//   their keys in parallel; then the cells shift or overwrite and the result
//   register is loaded. A new request is taken only after the last one has
//   passed its update step.
// Reset:
//   rst_n (synchronous, active low) empties the table and drops any pending
//   result. Slot contents are not cleared; only slots below the entry count
//   take part in a compare.
// Stalls:
//   While a result waits in the output register, the next request is still
//   accepted and compared; it holds in the update cycle until the waiting
//   result has been taken.
module sorted_key_value_table_core #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input logic       clk,
  input logic       rst_n,
  skvt_in_if.sink   in_chan,
  skvt_out_if.source out_chan
);
  import skvt_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  op_t                   op_r;
  key_t                  key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  val_in_t               out_value_r, out_value_nxt;

  logic                  accept;
  logic                  upd_go;
  cell_cmd_t             cmd;
  logic [63:0]           val_in_ext;
  logic [63:0]           hit_val_ext;
  logic                  hit;
  logic                  full;
  logic [VALUE_BITS-1:0] hit_value;

  key_t                  cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0] cell_value [CAPACITY];
  logic [VALUE_BITS-1:0] cell_hitv  [CAPACITY];
  logic [CAPACITY-1:0]   cell_lt;
  logic [CAPACITY-1:0]   cell_eq;
  logic [CAPACITY-1:0]   cell_vld;

  // Handshakes.
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign upd_go        = (state_r == ST_UPD) && (!out_valid_r || out_chan.ready);

  // Request capture; the value is masked to the stored width.
  assign val_in_ext = {32'd0, in_chan.value};

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= in_chan.operation;
      key_r <= in_chan.key;
      val_r <= val_in_ext[VALUE_BITS-1:0];
    end
  end

  // Reduction of the per-cell compare results.
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | cell_hitv[i];
    end
  end

  assign hit         = |cell_eq;
  assign full        = (count_r == CNT_W'(CAPACITY));
  assign hit_val_ext = 64'(hit_value);

  // Controller: issues the cell command and forms the result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    cmd            = '0;

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd.compare = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (upd_go) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = STAT_NOT_FOUND;
          out_value_nxt  = '0;
          unique case (op_r)
            OP_INSERT: begin
              if (hit) begin
                cmd.overwrite  = 1'b1;
                out_status_nxt = STAT_OVERWROTE;
              end else if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                cmd.insert     = 1'b1;
                count_nxt      = count_r + CNT_W'(1);
                out_status_nxt = STAT_INSERTED;
              end
            end
            OP_LOOKUP: begin
              if (hit) begin
                out_status_nxt = STAT_FOUND;
                out_value_nxt  = hit_val_ext[31:0];
              end
            end
            OP_REMOVE: begin
              if (hit) begin
                cmd.remove     = 1'b1;
                count_nxt      = count_r - CNT_W'(1);
                out_status_nxt = STAT_FOUND;
                out_value_nxt  = hit_val_ext[31:0];
              end
            end
            default: begin
              out_status_nxt = STAT_NOT_FOUND;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.value_out   = out_value_r;
  assign out_chan.entry_count = COUNT_W'(count_r);

  // Chain of cells, each wired to its lower and upper neighbour.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic                  p_lt;
    key_t                  p_key;
    logic [VALUE_BITS-1:0] p_value;
    key_t                  n_key;
    logic [VALUE_BITS-1:0] n_value;

    assign cell_vld[g] = (count_r > CNT_W'(g));

    if (g == 0) begin : g_first
      assign p_lt    = 1'b1;
      assign p_key   = cell_key[g];
      assign p_value = cell_value[g];
    end else begin : g_mid
      assign p_lt    = cell_lt[g-1];
      assign p_key   = cell_key[g-1];
      assign p_value = cell_value[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign n_key   = cell_key[g];
      assign n_value = cell_value[g];
    end else begin : g_below
      assign n_key   = cell_key[g+1];
      assign n_value = cell_value[g+1];
    end

    skvt_cell #(
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .bcast_key   (key_r),
      .bcast_value (val_r),
      .slot_valid  (cell_vld[g]),
      .prev_lt     (p_lt),
      .prev_key    (p_key),
      .prev_value  (p_value),
      .next_key    (n_key),
      .next_value  (n_value),
      .key_q       (cell_key[g]),
      .value_q     (cell_value[g]),
      .lt_q        (cell_lt[g]),
      .eq_q        (cell_eq[g]),
      .hit_value_q (cell_hitv[g])
    );
  end

endmodule

>>> src/skvt_cell.sv
// One slot of the sorted table: holds a key and a value, compares against the
// broadcast key and shifts to or from its neighbours. Depends on skvt_pkg.
module skvt_cell #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  skvt_pkg::cell_cmd_t   cmd,
  input  skvt_pkg::key_t        bcast_key,
  input  logic [VALUE_BITS-1:0] bcast_value,
  input  logic                  slot_valid,
  input  logic                  prev_lt,
  input  skvt_pkg::key_t        prev_key,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  skvt_pkg::key_t        next_key,
  input  logic [VALUE_BITS-1:0] next_value,
  output skvt_pkg::key_t        key_q,
  output logic [VALUE_BITS-1:0] value_q,
  output logic                  lt_q,
  output logic                  eq_q,
  output logic [VALUE_BITS-1:0] hit_value_q
);
  import skvt_pkg::*;

  key_t                  key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  lt_r;
  logic                  eq_r;
  logic [VALUE_BITS-1:0] hit_value_r;
  logic                  match;

  assign match = slot_valid && (key_r == bcast_key);

  // Compare results are held for the update cycle that follows.
  always_ff @(posedge clk) begin
    if (cmd.compare) begin
      lt_r        <= slot_valid && (key_r < bcast_key);
      eq_r        <= match;
      hit_value_r <= match ? value_r : '0;
    end
  end

  // Slot contents on insert: cells below the sorted position keep their entry,
  // the cell at the position takes the new pair and the cells above it shift.
  always_ff @(posedge clk) begin
    if (cmd.insert && !lt_r) begin
      if (prev_lt) begin
        key_r   <= bcast_key;
        value_r <= bcast_value;
      end else begin
        key_r   <= prev_key;
        value_r <= prev_value;
      end
    end else if (cmd.remove && !lt_r) begin
      key_r   <= next_key;
      value_r <= next_value;
    end else if (cmd.overwrite && eq_r) begin
      value_r <= bcast_value;
    end
  end

  assign key_q       = key_r;
  assign value_q     = value_r;
  assign lt_q        = lt_r;
  assign eq_q        = eq_r;
  assign hit_value_q = hit_value_r;

endmodule

>>> tb/sorted_key_value_table_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of sorted_key_value_table_core: inserts, lookups and removes
// against a shadow copy of the sorted table. Depends on skvt_pkg, skvt_in_if, skvt_out_if
// and the table core itself.
module sorted_key_value_table_core_test;
  import skvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 12;

  // The fourth operation code is not defined by the block and must change nothing.
  localparam op_t OP_UNUSED = 2'd3;

  typedef struct {
    status_t    status;
    val_in_t    value_out;
    count_out_t entry_count;
  } table_result_t;

  logic clk;
  logic rst_n;

  skvt_in_if  in_chan ();
  skvt_out_if out_chan ();

  sorted_key_value_table_core #(
    .CAPACITY   (TABLE_DEPTH),
    .VALUE_BITS (VALUE_WIDTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Shadow copy of the table, kept sorted by ascending unsigned key.
  key_t          shadow_keys [TABLE_DEPTH];
  val_in_t       shadow_vals [TABLE_DEPTH];
  int unsigned   held_entries = 0;

  table_result_t results_due [$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count = 0;
  bit            idling_on = 1'b1;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Overall cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_key_value_table_core regression: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Applies one transaction to the shadow table and returns the result it must produce.
  // VALUE_WIDTH equals the field width, so the stored value needs no masking.
  function automatic table_result_t shadow_table_update(op_t op, key_t k, val_in_t v);
    table_result_t res;
    int unsigned   pos;
    int unsigned   i;
    bit            hit;
    res.status    = STAT_NOT_FOUND;
    res.value_out = '0;
    pos = 0;
    for (i = 0; i < held_entries; i++) begin
      if (shadow_keys[i] < k) pos++;
    end
    hit = (pos < held_entries) && (shadow_keys[pos] == k);
    case (op)
      OP_INSERT: begin
        if (hit) begin
          shadow_vals[pos] = v;
          res.status = STAT_OVERWROTE;
        end else if (held_entries >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          for (i = held_entries; i > pos; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_vals[i] = shadow_vals[i-1];
          end
          shadow_keys[pos] = k;
          shadow_vals[pos] = v;
          held_entries++;
          res.status = STAT_INSERTED;
        end
      end
      OP_LOOKUP: begin
        if (hit) begin
          res.status    = STAT_FOUND;
          res.value_out = shadow_vals[pos];
        end
      end
      OP_REMOVE: begin
        if (hit) begin
          res.status    = STAT_FOUND;
          res.value_out = shadow_vals[pos];
          for (i = pos; i + 1 < held_entries; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_vals[i] = shadow_vals[i+1];
          end
          held_entries--;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = count_out_t'(held_entries);
    return res;
  endfunction

  // Sends one request and records its expected result once the transaction is accepted.
  // Valid is left high on return; a following gap or release lowers it.
  task automatic send_request(op_t op, key_t k, val_in_t v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.key       <= k;
    in_chan.value     <= v;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    results_due.push_back(shadow_table_update(op, k, v));
  endtask

  // Holds the request side quiet until every outstanding result has been returned.
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // A key that is probably absent: wide random, narrow, or next to a stored key.
  function automatic key_t fresh_key();
    key_t base;
    case ($urandom_range(0, 7))
      0: return {32'h0, 32'($urandom)};
      1: return {32'($urandom), 32'hFFFF_FFFF};
      2: return ($urandom_range(0, 1) != 0) ? key_t'('0) : key_t'('1);
      3: begin
        if (held_entries == 0) return {32'($urandom), 32'($urandom)};
        base = shadow_keys[$urandom_range(0, held_entries - 1)];
        return ($urandom_range(0, 1) != 0) ? base + 1 : base - 1;
      end
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  function automatic key_t held_key();
    if (held_entries == 0) return fresh_key();
    return shadow_keys[$urandom_range(0, held_entries - 1)];
  endfunction

  // Random transactions with weighted choice between new inserts, overwrites, lookup
  // hits, remove hits and noise (unused code, lookups and removes of absent keys).
  task automatic run_random_mix(int unsigned items, int unsigned w_new, int unsigned w_over,
                                int unsigned w_look, int unsigned w_del,
                                int unsigned w_noise);
    int unsigned pick;
    op_t         op;
    key_t        k;
    val_in_t     v;
    repeat (items) begin
      pick = $urandom_range(0, w_new + w_over + w_look + w_del + w_noise - 1);
      v    = $urandom;
      if (pick < w_new) begin
        op = OP_INSERT;
        k  = fresh_key();
      end else if (pick < w_new + w_over) begin
        op = OP_INSERT;
        k  = held_key();
      end else if (pick < w_new + w_over + w_look) begin
        op = OP_LOOKUP;
        k  = held_key();
      end else if (pick < w_new + w_over + w_look + w_del) begin
        op = OP_REMOVE;
        k  = held_key();
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_UNUSED;
          1:       op = OP_LOOKUP;
          default: op = OP_REMOVE;
        endcase
        k = fresh_key();
      end
      send_request(op, k, v);
    end
  endtask

  // Extremes of key and value, every operation, overwrite, misses and the unused code.
  task automatic test_directed();
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_REMOVE, '1, '0);
    send_request(OP_UNUSED, '0, '0);
    send_request(OP_INSERT, '1, '1);
    send_request(OP_INSERT, '0, '0);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, 32'h5555_5555);
    send_request(OP_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hAAAA_AAAA);
    send_request(OP_LOOKUP, '1, '0);
    send_request(OP_LOOKUP, '0, '1);
    send_request(OP_INSERT, '0, 32'hDEAD_BEEF);
    send_request(OP_LOOKUP, '0, '0);
    send_request(OP_UNUSED, '1, '1);
    send_request(OP_REMOVE, 64'h8000_0000_0000_0000, '1);
    send_request(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);
    send_request(OP_REMOVE, 64'h8000_0000_0000_0000, '0);
    send_request(OP_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    send_request(OP_REMOVE, '1, '0);
    send_request(OP_REMOVE, '0, '0);
    send_request(OP_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, '0);
    send_request(OP_LOOKUP, '1, '0);
  endtask

  // Insert-heavy traffic: the table fills, then new keys are refused while present
  // keys can still be overwritten.
  task automatic test_fill_to_capacity();
    run_random_mix(320, 14, 2, 2, 1, 1);
  endtask

  // Remove-heavy traffic from a full table, bracketed by full drains of the pipeline.
  task automatic test_drain_to_empty();
    wait_drained();
    run_random_mix(200, 2, 1, 2, 10, 2);
    wait_drained();
  endtask

  // Balanced traffic with idling on both sides, swinging between growth and shrinkage.
  task automatic test_mixed_traffic();
    run_random_mix(250, 6, 2, 3, 2, 2);
    run_random_mix(250, 2, 2, 3, 6, 2);
    run_random_mix(250, 8, 2, 2, 2, 1);
    run_random_mix(250, 3, 3, 3, 3, 3);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_back_to_back();
    idling_on = 1'b0;
    run_random_mix(200, 10, 2, 3, 2, 1);
    run_random_mix(180, 3, 2, 3, 6, 2);
  endtask

  // Result side: random stalls while idling is enabled.
  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && rst_n && $urandom_range(0, 4) == 0) begin
        out_chan.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_chan.ready <= 1'b1;
    end
  end

  // Compare each returned result with the oldest expectation.
  always @(posedge clk) begin : check_result
    table_result_t due;
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (results_due.size() == 0) begin
        report_mismatch("result returned with none expected");
      end else begin
        due = results_due.pop_front();
        if (out_chan.status !== due.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_chan.status, due.status));
        if (out_chan.value_out !== due.value_out)
          report_mismatch($sformatf("value_out %h, expected %h", out_chan.value_out,
                                    due.value_out));
        if (out_chan.entry_count !== due.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d", out_chan.entry_count,
                                    due.entry_count));
      end
    end
  end

  // Reset, test sequence and final verdict.
  initial begin
    rst_n             <= 1'b0;
    in_chan.valid     <= 1'b0;
    in_chan.operation <= OP_INSERT;
    in_chan.key       <= '0;
    in_chan.value     <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_fill_to_capacity();
    test_drain_to_empty();
    test_mixed_traffic();
    test_back_to_back();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("sorted_key_value_table_core regression: pass");
    end else begin
      $display("sorted_key_value_table_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
src/skvt_pkg.sv
src/skvt_in_if.sv
src/skvt_out_if.sv
src/skvt_cell.sv
src/sorted_key_value_table_core.sv
tb/sorted_key_value_table_core_test.sv
